@@ src/cga_crtc_register_block_macros.svh @@
// Assertion macros for the CGA CRTC register block checker.
// Used by cga_crtc_checker.sv; no other dependencies.
`ifndef CGA_CRTC_REGISTER_BLOCK_MACROS_SVH
`define CGA_CRTC_REGISTER_BLOCK_MACROS_SVH

// same-cycle implication, disabled while rst is true
`define CGA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while rst is true
`define CGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cga_crtc_pkg.sv @@
// Package for the CGA CRTC register block: port codes, register indexes,
// display mode codes and the transaction payload structs. No dependencies.
`timescale 1ns / 1ps

package cga_crtc_pkg;

    localparam int CRTC_REG_COUNT = 16;
    localparam int CRTC_IDX_W     = $clog2(CRTC_REG_COUNT);

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [9:0] PORT_INDEX = 10'h3D4;
    localparam logic [9:0] PORT_DATA  = 10'h3D5;
    localparam logic [9:0] PORT_MODE  = 10'h3D8;
    localparam logic [9:0] PORT_COLOR = 10'h3D9;
    localparam logic [9:0] PORT_STAT  = 10'h3DA;

    localparam logic [7:0] REG_CURSOR_START = 8'h0A;
    localparam logic [7:0] REG_CURSOR_END   = 8'h0B;
    localparam logic [7:0] REG_START_HI     = 8'h0C;
    localparam logic [7:0] REG_START_LO     = 8'h0D;
    localparam logic [7:0] REG_CURSOR_HI    = 8'h0E;
    localparam logic [7:0] REG_CURSOR_LO    = 8'h0F;

    localparam logic [1:0] DMODE_TEXT40 = 2'd0;
    localparam logic [1:0] DMODE_TEXT80 = 2'd1;
    localparam logic [1:0] DMODE_GFX320 = 2'd2;
    localparam logic [1:0] DMODE_GFX640 = 2'd3;

    localparam logic [7:0] STAT_IN_VSYNC  = 8'h00;
    localparam logic [7:0] STAT_OUT_VSYNC = 8'h09;
    localparam logic [7:0] READ_FLOAT     = 8'hFF;

    typedef struct packed {
        logic       operation;
        logic [9:0] port_address;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        video_enabled;
        logic [1:0]  display_mode;
        logic        blink_enable;
        logic [1:0]  palette_index;
        logic [3:0]  background_color;
        logic [3:0]  foreground_color;
        logic [16:0] start_offset;
        logic        cursor_visible;
        logic [11:0] cursor_shape;
        logic [10:0] cursor_row;
        logic [6:0]  cursor_col;
    } out_item_t;

endpackage

@@ src/cga_crtc_register_block.sv @@
// CGA CRTC register block: each accepted input transaction gives a registered result in the next cycle.
// Throughput one transaction per cycle while the result is taken (m_ready); the result register frees as it is taken.
// All state updates and the cursor divide happen in the accepting cycle.
// Reset (aresetn low, synchronous) clears all state registers and the result valid; the result data is not reset.
// Depends on cga_crtc_pkg and cga_crtc_cursor_pos.
`timescale 1ns / 1ps

module cga_crtc_register_block
    import cga_crtc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [7:0]  crtc_index_reg, crtc_index_next;
    logic [7:0]  crtc_regs_reg [CRTC_REG_COUNT];
    logic [7:0]  crtc_regs_next [CRTC_REG_COUNT];
    logic [7:0]  mode_ctl_reg, mode_ctl_next;
    logic [7:0]  color_ctl_reg, color_ctl_next;
    logic [2:0]  vsync_count_reg, vsync_count_next;
    logic [1:0]  shown_mode_reg, shown_mode_next;
    logic        video_on_reg, video_on_next;
    logic        blink_reg, blink_next;
    logic [1:0]  palette_reg, palette_next;
    logic [3:0]  back_color_reg, back_color_next;
    logic [3:0]  fore_color_reg, fore_color_next;
    logic [16:0] start_addr_reg, start_addr_next;
    logic        cursor_on_reg, cursor_on_next;
    logic [11:0] cursor_lines_reg, cursor_lines_next;
    logic [10:0] cursor_row_reg, cursor_row_next;
    logic [6:0]  cursor_col_reg, cursor_col_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    logic        accept;
    logic        is_write;
    logic        crtc_wr;
    logic        apply_en;
    logic [7:0]  rd;
    logic [15:0] cursor_addr;
    logic [10:0] calc_row;
    logic [6:0]  calc_col;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign is_write    = (s_data.operation == OP_WRITE);
    assign crtc_wr     = accept && is_write && (s_data.port_address == PORT_DATA)
                         && (crtc_index_reg < 8'(CRTC_REG_COUNT));
    assign cursor_addr = {crtc_regs_next[REG_CURSOR_HI[CRTC_IDX_W-1:0]],
                          crtc_regs_next[REG_CURSOR_LO[CRTC_IDX_W-1:0]]};

    cga_crtc_cursor_pos u_cursor_pos (
        .pos    (cursor_addr),
        .wide80 (shown_mode_reg == DMODE_TEXT80),
        .row    (calc_row),
        .col    (calc_col)
    );

    // register file and port registers
    always_comb begin
        crtc_index_next  = crtc_index_reg;
        mode_ctl_next    = mode_ctl_reg;
        color_ctl_next   = color_ctl_reg;
        vsync_count_next = vsync_count_reg;
        rd               = 8'h00;
        for (int i = 0; i < CRTC_REG_COUNT; i++) begin
            crtc_regs_next[i] = crtc_regs_reg[i];
            if (crtc_wr && crtc_index_reg == 8'(i)) begin
                crtc_regs_next[i] = s_data.write_data;
            end
        end
        if (accept) begin
            if (is_write) begin
                case (s_data.port_address)
                    PORT_INDEX: crtc_index_next = s_data.write_data;
                    PORT_MODE:  mode_ctl_next   = s_data.write_data;
                    PORT_COLOR: color_ctl_next  = s_data.write_data;
                    default:    ;
                endcase
            end else begin
                case (s_data.port_address)
                    PORT_INDEX: rd = 8'h00;
                    PORT_DATA: begin
                        if (crtc_index_reg == REG_CURSOR_HI) begin
                            rd = crtc_regs_reg[REG_CURSOR_HI[CRTC_IDX_W-1:0]];
                        end else if (crtc_index_reg == REG_CURSOR_LO) begin
                            rd = crtc_regs_reg[REG_CURSOR_LO[CRTC_IDX_W-1:0]];
                        end
                    end
                    PORT_COLOR: rd = color_ctl_reg;
                    PORT_STAT: begin
                        vsync_count_next = vsync_count_reg + 3'd1;
                        rd = (vsync_count_next != 3'd0) ? STAT_OUT_VSYNC : STAT_IN_VSYNC;
                    end
                    default: rd = READ_FLOAT;
                endcase
            end
        end
    end

    // derived display state
    always_comb begin
        shown_mode_next   = shown_mode_reg;
        video_on_next     = video_on_reg;
        blink_next        = blink_reg;
        palette_next      = palette_reg;
        back_color_next   = back_color_reg;
        fore_color_next   = fore_color_reg;
        start_addr_next   = start_addr_reg;
        cursor_on_next    = cursor_on_reg;
        cursor_lines_next = cursor_lines_reg;
        cursor_row_next   = cursor_row_reg;
        cursor_col_next   = cursor_col_reg;
        apply_en          = accept && is_write && (s_data.port_address == PORT_MODE
                                                || s_data.port_address == PORT_COLOR);

        if (crtc_wr) begin
            case (crtc_index_reg)
                REG_CURSOR_START, REG_CURSOR_END: begin
                    if (crtc_index_reg == REG_CURSOR_START) begin
                        cursor_on_next =
                            (crtc_regs_next[REG_CURSOR_START[CRTC_IDX_W-1:0]][7:6] != 2'b00);
                    end
                    cursor_lines_next = {
                        crtc_regs_next[REG_CURSOR_START[CRTC_IDX_W-1:0]][4:0], 1'b0,
                        crtc_regs_next[REG_CURSOR_END[CRTC_IDX_W-1:0]][4:0], 1'b0};
                end
                REG_START_HI, REG_START_LO: begin
                    start_addr_next = {crtc_regs_next[REG_START_HI[CRTC_IDX_W-1:0]],
                                       crtc_regs_next[REG_START_LO[CRTC_IDX_W-1:0]], 1'b0};
                    apply_en = 1'b1;
                end
                REG_CURSOR_HI, REG_CURSOR_LO: begin
                    if (shown_mode_reg == DMODE_TEXT40 || shown_mode_reg == DMODE_TEXT80) begin
                        cursor_row_next = calc_row;
                        cursor_col_next = calc_col;
                    end
                end
                default: ;
            endcase
        end

        if (apply_en) begin
            if (!mode_ctl_next[3]) begin
                video_on_next = 1'b0;
            end else begin
                video_on_next = 1'b1;
                if (!mode_ctl_next[1]) begin
                    shown_mode_next = mode_ctl_next[0] ? DMODE_TEXT80 : DMODE_TEXT40;
                    blink_next      = mode_ctl_next[5];
                end else if (!mode_ctl_next[4]) begin
                    shown_mode_next = DMODE_GFX320;
                    palette_next    = color_ctl_next[5:4];
                    back_color_next = color_ctl_next[3:0];
                end else begin
                    shown_mode_next = DMODE_GFX640;
                    fore_color_next = color_ctl_next[3:0];
                end
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next                 = 1'b1;
            m_data_next.read_data        = rd;
            m_data_next.video_enabled    = video_on_next;
            m_data_next.display_mode     = shown_mode_next;
            m_data_next.blink_enable     = blink_next;
            m_data_next.palette_index    = palette_next;
            m_data_next.background_color = back_color_next;
            m_data_next.foreground_color = fore_color_next;
            m_data_next.start_offset     = start_addr_next;
            m_data_next.cursor_visible   = cursor_on_next;
            m_data_next.cursor_shape     = cursor_lines_next;
            m_data_next.cursor_row       = cursor_row_next;
            m_data_next.cursor_col       = cursor_col_next;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crtc_index_reg   <= '0;
            for (int i = 0; i < CRTC_REG_COUNT; i++) begin
                crtc_regs_reg[i] <= '0;
            end
            mode_ctl_reg     <= '0;
            color_ctl_reg    <= '0;
            vsync_count_reg  <= '0;
            shown_mode_reg   <= DMODE_TEXT40;
            video_on_reg     <= 1'b0;
            blink_reg        <= 1'b0;
            palette_reg      <= '0;
            back_color_reg   <= '0;
            fore_color_reg   <= '0;
            start_addr_reg   <= '0;
            cursor_on_reg    <= 1'b0;
            cursor_lines_reg <= '0;
            cursor_row_reg   <= '0;
            cursor_col_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            crtc_index_reg   <= crtc_index_next;
            for (int i = 0; i < CRTC_REG_COUNT; i++) begin
                crtc_regs_reg[i] <= crtc_regs_next[i];
            end
            mode_ctl_reg     <= mode_ctl_next;
            color_ctl_reg    <= color_ctl_next;
            vsync_count_reg  <= vsync_count_next;
            shown_mode_reg   <= shown_mode_next;
            video_on_reg     <= video_on_next;
            blink_reg        <= blink_next;
            palette_reg      <= palette_next;
            back_color_reg   <= back_color_next;
            fore_color_reg   <= fore_color_next;
            start_addr_reg   <= start_addr_next;
            cursor_on_reg    <= cursor_on_next;
            cursor_lines_reg <= cursor_lines_next;
            cursor_row_reg   <= cursor_row_next;
            cursor_col_reg   <= cursor_col_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

@@ src/cga_crtc_cursor_pos.sv @@
// Splits a 16-bit cursor address into text row and column for 40 or 80 columns.
// Depends on cga_crtc_pkg (imported for house consistency); purely combinational.
`timescale 1ns / 1ps

module cga_crtc_cursor_pos
    import cga_crtc_pkg::*;
(
    input  logic [15:0] pos,
    input  logic        wide80,
    output logic [10:0] row,
    output logic [6:0]  col
);

    // pos/40 = (pos>>3)/5, pos/80 = (pos>>4)/5; x/5 via 52429/2^18 (exact for x < 2^13)
    localparam logic [15:0] RECIP5 = 16'd52429;
    localparam int          SHIFT5 = 18;

    logic [12:0] quo_in;
    logic [28:0] prod;
    logic [10:0] quo;
    logic [13:0] quo_x5;
    logic [2:0]  rem5;

    always_comb begin
        quo_in = wide80 ? {1'b0, pos[15:4]} : pos[15:3];
        prod   = 29'(quo_in) * 29'(RECIP5);
        quo    = prod[SHIFT5 +: 11];
        quo_x5 = 14'(quo) * 14'd5;
        rem5   = 3'(14'(quo_in) - quo_x5);
        row    = quo;
        col    = wide80 ? {rem5, pos[3:0]} : {1'b0, rem5, pos[2:0]};
    end

endmodule

@@ src/cga_crtc_checker.sv @@
// Port-level checker for cga_crtc_register_block, bound into each instance of it.
// Depends on cga_crtc_pkg and cga_crtc_register_block_macros.svh.
`timescale 1ns / 1ps
`include "cga_crtc_register_block_macros.svh"

module cga_crtc_checker
    import cga_crtc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `CGA_ASSERT_NEXT(a_reset_clears, aclk, 1'b0, !aresetn, !m_valid, "result valid after reset")
    `CGA_ASSERT_NEXT(a_accept_gives_result, aclk, !aresetn, s_valid && s_ready, m_valid, "accepted transaction gave no result")
    `CGA_ASSERT_IMPLY(a_no_overwrite, aclk, !aresetn, m_valid && !m_ready, !s_ready, "input taken while result stalled")
    `CGA_ASSERT_NEXT(a_write_reads_zero, aclk, !aresetn, s_valid && s_ready && s_data.operation == OP_WRITE, m_data.read_data == 8'h00, "write transaction returned nonzero data")
    `CGA_ASSERT_NEXT(a_result_holds, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

endmodule

bind cga_crtc_register_block cga_crtc_checker u_cga_crtc_checker (.*);

@@ tb/sv/cga_crtc_register_block_test.sv @@
// Testbench for cga_crtc_register_block: a queue-fed driver and a clocked monitor check
// each result transaction against an in-bench model of the CRTC/mode/colour registers.
// Depends on cga_crtc_pkg and the cga_crtc_register_block RTL.
`timescale 1ns / 1ps

module cga_crtc_register_block_test;
    import cga_crtc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1600;

    localparam logic [7:0] MODE_80COL = 8'h01;
    localparam logic [7:0] MODE_GFX   = 8'h02;
    localparam logic [7:0] MODE_VIDEO = 8'h08;
    localparam logic [7:0] MODE_HIRES = 8'h10;
    localparam logic [7:0] MODE_BLINK = 8'h20;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    cga_crtc_register_block u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];

    int cycle_count     = 0;
    int items_launched  = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int write_count     = 0;
    int read_count      = 0;
    int status_polls    = 0;
    int error_count     = 0;
    int send_gap        = 0;
    int take_gap        = 0;

    // register model
    logic [7:0]  sel_index = '0;
    logic [7:0]  crtc_file[CRTC_REG_COUNT];
    logic [7:0]  mode_byte = '0;
    logic [7:0]  color_byte = '0;
    logic [2:0]  vsync_ctr = '0;
    logic [1:0]  shown_mode = DMODE_TEXT40;
    logic        video_on = 1'b0;
    logic        blink_on = 1'b0;
    logic [1:0]  palette_sel = '0;
    logic [3:0]  back_color = '0;
    logic [3:0]  fore_color = '0;
    logic [16:0] frame_start = '0;
    logic        cursor_shown = 1'b0;
    logic [11:0] cursor_lines = '0;
    logic [10:0] cursor_row = '0;
    logic [6:0]  cursor_col = '0;

    initial begin
        for (int i = 0; i < CRTC_REG_COUNT; i++) crtc_file[i] = '0;
    end

    function automatic void apply_mode_settings();
        if ((mode_byte & MODE_VIDEO) == 0) begin
            video_on = 1'b0;
            return;
        end
        if ((mode_byte & MODE_GFX) == 0) begin
            shown_mode = ((mode_byte & MODE_80COL) != 0) ? DMODE_TEXT80 : DMODE_TEXT40;
            blink_on = (mode_byte & MODE_BLINK) != 0;
        end else if ((mode_byte & MODE_HIRES) == 0) begin
            shown_mode = DMODE_GFX320;
            palette_sel = {color_byte[5], color_byte[4]};
            back_color = color_byte[3:0];
        end else begin
            shown_mode = DMODE_GFX640;
            fore_color = color_byte[3:0];
        end
        video_on = 1'b1;
    endfunction

    function automatic out_item_t predict_access(input in_item_t acc);
        out_item_t res;
        int        pos;
        int        cols;
        res = '0;
        if (acc.operation == OP_WRITE) begin
            case (acc.port_address)
                PORT_INDEX: sel_index = acc.write_data;
                PORT_DATA: begin
                    if (sel_index < 8'(CRTC_REG_COUNT)) begin
                        crtc_file[sel_index[3:0]] = acc.write_data;
                        case (sel_index)
                            REG_CURSOR_START, REG_CURSOR_END: begin
                                if (sel_index == REG_CURSOR_START)
                                    cursor_shown = crtc_file[REG_CURSOR_START][7:5] >= 3'd2;
                                cursor_lines = {crtc_file[REG_CURSOR_START][4:0], 1'b0,
                                                crtc_file[REG_CURSOR_END][4:0], 1'b0};
                            end
                            REG_START_HI, REG_START_LO: begin
                                frame_start = {crtc_file[REG_START_HI],
                                               crtc_file[REG_START_LO], 1'b0};
                                apply_mode_settings();
                            end
                            REG_CURSOR_HI, REG_CURSOR_LO: begin
                                if (shown_mode == DMODE_TEXT40 || shown_mode == DMODE_TEXT80) begin
                                    cols = (shown_mode == DMODE_TEXT80) ? 80 : 40;
                                    pos = 32'({crtc_file[REG_CURSOR_HI],
                                               crtc_file[REG_CURSOR_LO]});
                                    cursor_row = 11'(pos / cols);
                                    cursor_col = 7'(pos % cols);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                PORT_MODE: begin
                    mode_byte = acc.write_data;
                    apply_mode_settings();
                end
                PORT_COLOR: begin
                    color_byte = acc.write_data;
                    apply_mode_settings();
                end
                default: ;
            endcase
        end else begin
            case (acc.port_address)
                PORT_INDEX: res.read_data = '0;
                PORT_DATA: begin
                    if (sel_index == REG_CURSOR_HI || sel_index == REG_CURSOR_LO)
                        res.read_data = crtc_file[sel_index[3:0]];
                end
                PORT_COLOR: res.read_data = color_byte;
                PORT_STAT: begin
                    vsync_ctr = vsync_ctr + 3'd1;
                    res.read_data = (vsync_ctr != 0) ? STAT_OUT_VSYNC : STAT_IN_VSYNC;
                end
                default: res.read_data = READ_FLOAT;
            endcase
        end
        res.video_enabled    = video_on;
        res.display_mode     = shown_mode;
        res.blink_enable     = blink_on;
        res.palette_index    = palette_sel;
        res.background_color = back_color;
        res.foreground_color = fore_color;
        res.start_offset     = frame_start;
        res.cursor_visible   = cursor_shown;
        res.cursor_shape     = cursor_lines;
        res.cursor_row       = cursor_row;
        res.cursor_col       = cursor_col;
        return res;
    endfunction

    // back-to-back bursts for 150 of every 600 transactions, otherwise mostly short gaps
    function automatic int draw_gap(input int seq);
        int r;
        if ((seq / 150) % 4 == 1) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_field(input string field, input int unsigned got,
                                input int unsigned want);
        if (got !== want) begin
            $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_checked, field, got, want);
            error_count++;
        end
    endtask

    task automatic push_access(input logic op, input logic [9:0] port, input logic [7:0] data);
        in_item_t acc;
        acc.operation = op;
        acc.port_address = port;
        acc.write_data = data;
        pending_items.push_back(acc);
    endtask

    function automatic logic [7:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'($urandom_range(10, 15));
        if (r < 80) return 8'($urandom_range(0, 31));
        return 8'($urandom_range(0, 255));
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
                send_gap <= draw_gap(items_launched);
                items_launched <= items_launched + 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result-side stalls
    always @(posedge aclk) begin : take_side
        int g;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            g = draw_gap(results_checked);
            take_gap <= g;
            m_ready <= (g == 0);
        end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            m_ready <= (take_gap == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: check outgoing first, since a result never belongs to the same-edge input
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_field("unexpected result", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    report_field("read_data", 32'(m_data.read_data), 32'(want.read_data));
                    report_field("video_enabled", 32'(m_data.video_enabled),
                                 32'(want.video_enabled));
                    report_field("display_mode", 32'(m_data.display_mode),
                                 32'(want.display_mode));
                    report_field("blink_enable", 32'(m_data.blink_enable),
                                 32'(want.blink_enable));
                    report_field("palette_index", 32'(m_data.palette_index),
                                 32'(want.palette_index));
                    report_field("background_color", 32'(m_data.background_color),
                                 32'(want.background_color));
                    report_field("foreground_color", 32'(m_data.foreground_color),
                                 32'(want.foreground_color));
                    report_field("start_offset", 32'(m_data.start_offset),
                                 32'(want.start_offset));
                    report_field("cursor_visible", 32'(m_data.cursor_visible),
                                 32'(want.cursor_visible));
                    report_field("cursor_shape", 32'(m_data.cursor_shape),
                                 32'(want.cursor_shape));
                    report_field("cursor_row", 32'(m_data.cursor_row), 32'(want.cursor_row));
                    report_field("cursor_col", 32'(m_data.cursor_col), 32'(want.cursor_col));
                end
                results_checked++;
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_access(s_data));
                items_accepted++;
                if (s_data.operation == OP_WRITE) write_count++;
                else read_count++;
                if (s_data.operation == OP_READ && s_data.port_address == PORT_STAT)
                    status_polls++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("cga_crtc_register_block test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int total;
        int r;
        int n;

        // directed: reset reads, extremes, every mode path but text40, corner cases
        push_access(OP_READ, PORT_STAT, 8'h00);
        push_access(OP_READ, PORT_DATA, 8'hFF);
        push_access(OP_READ, PORT_MODE, 8'h00);
        push_access(OP_READ, 10'h000, 8'h00);
        push_access(OP_WRITE, PORT_INDEX, REG_CURSOR_START);
        push_access(OP_WRITE, PORT_DATA, 8'hFF);
        push_access(OP_WRITE, PORT_INDEX, REG_CURSOR_END);
        push_access(OP_WRITE, PORT_DATA, 8'h1F);
        push_access(OP_WRITE, PORT_INDEX, REG_CURSOR_HI);
        push_access(OP_WRITE, PORT_DATA, 8'hFF);
        push_access(OP_WRITE, PORT_INDEX, REG_CURSOR_LO);
        push_access(OP_WRITE, PORT_DATA, 8'hFF);
        push_access(OP_READ, PORT_DATA, 8'h00);
        push_access(OP_WRITE, PORT_MODE, MODE_VIDEO | MODE_HIRES | MODE_80COL | MODE_BLINK);
        push_access(OP_WRITE, PORT_COLOR, 8'hFF);
        push_access(OP_WRITE, PORT_MODE, MODE_VIDEO | MODE_GFX);
        push_access(OP_WRITE, PORT_MODE, MODE_VIDEO | MODE_GFX | MODE_HIRES);
        push_access(OP_WRITE, PORT_MODE, MODE_GFX);
        push_access(OP_WRITE, PORT_INDEX, REG_START_HI);
        push_access(OP_WRITE, PORT_DATA, 8'hFF);
        push_access(OP_WRITE, PORT_INDEX, REG_START_LO);
        push_access(OP_WRITE, PORT_DATA, 8'hFF);
        push_access(OP_WRITE, PORT_INDEX, 8'hFF);
        push_access(OP_WRITE, PORT_DATA, 8'h55);
        push_access(OP_WRITE, PORT_STAT, 8'hFF);
        push_access(OP_WRITE, 10'h3FF, 8'h00);
        push_access(OP_READ, PORT_COLOR, 8'h00);
        for (int i = 0; i < 8; i++) push_access(OP_READ, PORT_STAT, 8'h00);

        // random: mostly well-formed index/data pairs and mode changes, some noise
        total = pending_items.size();
        while (total < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                push_access(OP_WRITE, PORT_INDEX, pick_index());
                push_access(OP_WRITE, PORT_DATA, 8'($urandom_range(0, 255)));
                n = 2;
                if ($urandom_range(0, 3) == 0) begin
                    push_access(OP_READ, PORT_DATA, 8'($urandom_range(0, 255)));
                    n++;
                end
            end else if (r < 50) begin
                push_access(OP_WRITE, PORT_MODE,
                            8'($urandom_range(0, 255)) | (($urandom_range(0, 3) != 0) ?
                            MODE_VIDEO : 8'h00));
                n = 1;
            end else if (r < 60) begin
                push_access(OP_WRITE, PORT_COLOR, 8'($urandom_range(0, 255)));
                n = 1;
            end else if (r < 78) begin
                case ($urandom_range(0, 4))
                    0: push_access(OP_READ, PORT_INDEX, 8'($urandom_range(0, 255)));
                    1: push_access(OP_READ, PORT_DATA, 8'($urandom_range(0, 255)));
                    2: push_access(OP_READ, PORT_MODE, 8'($urandom_range(0, 255)));
                    3: push_access(OP_READ, PORT_COLOR, 8'($urandom_range(0, 255)));
                    default: push_access(OP_READ, PORT_STAT, 8'($urandom_range(0, 255)));
                endcase
                n = 1;
            end else if (r < 88) begin
                n = $urandom_range(2, 10);
                for (int i = 0; i < n; i++)
                    push_access(OP_READ, PORT_STAT, 8'($urandom_range(0, 255)));
            end else begin
                push_access(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                            8'($urandom_range(0, 255)));
                n = 1;
            end
            total += n;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted < total) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d port accesses (%0d writes, %0d reads, %0d status polls)",
                 items_accepted, write_count, read_count, status_polls);
        $display("Compared %0d result transactions field by field, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0) begin
            $display("cga_crtc_register_block test passed");
        end else begin
            $display("cga_crtc_register_block test failed");
        end
        $finish;
    end

endmodule
